>>> hw/rtl/tplw_pkg.sv
// ----------------------------------------------------------------------------
// tplw_pkg: shared definitions for the two-level page table walker
// Store geometry, entry flags, status codes, and the microcode table that
// drives the walker's sequencer.
// ----------------------------------------------------------------------------
package tplw_pkg;

	// Store geometry: FRAMES frames of 1024 words each.
	localparam int FRAMES  = 64;
	localparam int FRAME_W = $clog2(FRAMES);
	localparam int IDX_W   = 10;
	localparam int ADDR_W  = FRAME_W + IDX_W;
	localparam int DEPTH   = FRAMES * 1024;
	localparam int NEXT_W  = 9;
	localparam int PFN_W   = 20;
	localparam int DATA_W  = 40;

	localparam int KERNEL_FIRST = 768;
	localparam int SELF_MAP     = 1023;

	typedef logic [31:0] word_t;

	// Entry flag bits.
	localparam logic [11:0] FLAG_P = 12'h001;
	localparam logic [11:0] FLAG_W = 12'h002;
	localparam logic [11:0] FLAG_U = 12'h004;

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_FRAME  = 2'd1;
	localparam logic [1:0] STATUS_BAD_FRAME = 2'd2;

	// Request kinds.
	localparam logic ACT_CREATE = 1'b0;
	localparam logic ACT_PAGE   = 1'b1;

	// Configuration register indexes.
	localparam logic REG_FIRST_FREE = 1'b0;
	localparam logic REG_KERNEL_DIR = 1'b1;

	// Microcode step addresses.
	typedef logic [4:0] step_t;
	localparam step_t S_CLR       = 5'd0;
	localparam step_t S_WAIT      = 5'd1;
	localparam step_t S_DISP      = 5'd2;
	localparam step_t S_CR_KCHK   = 5'd3;
	localparam step_t S_CR_FCHK   = 5'd4;
	localparam step_t S_CR_ALLOC  = 5'd5;
	localparam step_t S_CR_CLR    = 5'd6;
	localparam step_t S_CR_CPRD   = 5'd7;
	localparam step_t S_CR_CPWR   = 5'd8;
	localparam step_t S_CR_SELF   = 5'd9;
	localparam step_t S_PG_RDDIR  = 5'd10;
	localparam step_t S_PG_DCHK   = 5'd11;
	localparam step_t S_PG_TFCHK  = 5'd12;
	localparam step_t S_PG_TALLOC = 5'd13;
	localparam step_t S_PG_TOK    = 5'd14;
	localparam step_t S_PG_RDTBL  = 5'd15;
	localparam step_t S_PG_PCHK   = 5'd16;
	localparam step_t S_PG_PFCHK  = 5'd17;
	localparam step_t S_PG_PALLOC = 5'd18;
	localparam step_t S_PG_HIT    = 5'd19;
	localparam step_t S_FAIL1     = 5'd20;
	localparam step_t S_FAIL2     = 5'd21;
	localparam step_t S_RESULT    = 5'd22;

	// Datapath operations selected by a control word.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_WAIT,
		OP_CR_ALLOC,
		OP_CR_CLR,
		OP_CR_CPRD,
		OP_CR_CPWR,
		OP_CR_SELF,
		OP_RD_DIR,
		OP_T_ALLOC,
		OP_T_TAKE,
		OP_RD_TBL,
		OP_P_ALLOC,
		OP_HIT,
		OP_FAIL1,
		OP_FAIL2,
		OP_RESULT
	} op_t;

	// Jump conditions tested by the sequencer.
	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_ACCEPT,
		C_CLR_DONE,
		C_PAGE,
		C_KERN_BAD,
		C_NO_FRAME,
		C_IDX_CLR_MORE,
		C_IDX_CPY_MORE,
		C_ENTRY_P,
		C_TBL_BAD,
		C_OUT_FREE
	} cond_t;

	// One control word: when the condition holds the step counter jumps to
	// target; otherwise it stays put if hold is set, or moves to the next step.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  hold;
	} ctrl_t;

	// Status from the datapath that the conditions test.
	typedef struct packed {
		logic clr_done;
		logic accept;
		logic page;
		logic kern_bad;
		logic no_frame;
		logic idx_clr_more;
		logic idx_cpy_more;
		logic entry_p;
		logic tbl_bad;
		logic out_free;
	} flags_t;

	function automatic ctrl_t uword(op_t o, cond_t c, step_t t, logic h);
		ctrl_t w;
		w.op     = o;
		w.cond   = c;
		w.target = t;
		w.hold   = h;
		return w;
	endfunction

	// The walker program.
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		case (s)
			S_CLR:       w = uword(OP_CLR,      C_CLR_DONE,     S_WAIT,      1'b1);
			S_WAIT:      w = uword(OP_WAIT,     C_ACCEPT,       S_DISP,      1'b1);
			S_DISP:      w = uword(OP_NONE,     C_PAGE,         S_PG_RDDIR,  1'b0);
			S_CR_KCHK:   w = uword(OP_NONE,     C_KERN_BAD,     S_FAIL2,     1'b0);
			S_CR_FCHK:   w = uword(OP_NONE,     C_NO_FRAME,     S_FAIL1,     1'b0);
			S_CR_ALLOC:  w = uword(OP_CR_ALLOC, C_NONE,         S_WAIT,      1'b0);
			S_CR_CLR:    w = uword(OP_CR_CLR,   C_IDX_CLR_MORE, S_CR_CLR,    1'b0);
			S_CR_CPRD:   w = uword(OP_CR_CPRD,  C_NONE,         S_WAIT,      1'b0);
			S_CR_CPWR:   w = uword(OP_CR_CPWR,  C_IDX_CPY_MORE, S_CR_CPRD,   1'b0);
			S_CR_SELF:   w = uword(OP_CR_SELF,  C_ALWAYS,       S_RESULT,    1'b0);
			S_PG_RDDIR:  w = uword(OP_RD_DIR,   C_NONE,         S_WAIT,      1'b0);
			S_PG_DCHK:   w = uword(OP_NONE,     C_ENTRY_P,      S_PG_TOK,    1'b0);
			S_PG_TFCHK:  w = uword(OP_NONE,     C_NO_FRAME,     S_FAIL1,     1'b0);
			S_PG_TALLOC: w = uword(OP_T_ALLOC,  C_ALWAYS,       S_PG_RDTBL,  1'b0);
			S_PG_TOK:    w = uword(OP_T_TAKE,   C_TBL_BAD,      S_FAIL2,     1'b0);
			S_PG_RDTBL:  w = uword(OP_RD_TBL,   C_NONE,         S_WAIT,      1'b0);
			S_PG_PCHK:   w = uword(OP_NONE,     C_ENTRY_P,      S_PG_HIT,    1'b0);
			S_PG_PFCHK:  w = uword(OP_NONE,     C_NO_FRAME,     S_FAIL1,     1'b0);
			S_PG_PALLOC: w = uword(OP_P_ALLOC,  C_ALWAYS,       S_RESULT,    1'b0);
			S_PG_HIT:    w = uword(OP_HIT,      C_ALWAYS,       S_RESULT,    1'b0);
			S_FAIL1:     w = uword(OP_FAIL1,    C_ALWAYS,       S_RESULT,    1'b0);
			S_FAIL2:     w = uword(OP_FAIL2,    C_ALWAYS,       S_RESULT,    1'b0);
			S_RESULT:    w = uword(OP_RESULT,   C_OUT_FREE,     S_WAIT,      1'b1);
			default:     w = uword(OP_NONE,     C_ALWAYS,       S_WAIT,      1'b0);
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/tplw_seq.sv
// ----------------------------------------------------------------------------
// tplw_seq: microcode sequencer of the page table walker
// Holds the step counter, reads the control word for the current step and
// picks the next step from the word's jump condition.
// ----------------------------------------------------------------------------
module tplw_seq
	import tplw_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctrl_t  ctrl
);

	step_t upc_q;
	step_t upc_next;
	logic  take;

	// Control word for the current step.
	assign ctrl = ucode(upc_q);

	// Evaluate the jump condition.
	always_comb begin
		case (ctrl.cond)
			C_NONE:         take = 1'b0;
			C_ALWAYS:       take = 1'b1;
			C_ACCEPT:       take = flags.accept;
			C_CLR_DONE:     take = flags.clr_done;
			C_PAGE:         take = flags.page;
			C_KERN_BAD:     take = flags.kern_bad;
			C_NO_FRAME:     take = flags.no_frame;
			C_IDX_CLR_MORE: take = flags.idx_clr_more;
			C_IDX_CPY_MORE: take = flags.idx_cpy_more;
			C_ENTRY_P:      take = flags.entry_p;
			C_TBL_BAD:      take = flags.tbl_bad;
			C_OUT_FREE:     take = flags.out_free;
			default:        take = 1'b0;
		endcase
	end

	// Jump, hold or step on.
	always_comb begin
		if (take) begin
			upc_next = ctrl.target;
		end else if (ctrl.hold) begin
			upc_next = upc_q;
		end else begin
			upc_next = step_t'(upc_q + 1'b1);
		end
	end

	// Step counter; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_CLR;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

>>> hw/rtl/two_level_page_table_walk_alloc.sv
// ----------------------------------------------------------------------------
// two_level_page_table_walk_alloc: page table walker with frame allocator
// Keeps page directories and tables in an internal word store, creates new
// directories and maps pages on request, handing out frames from a counter.
// ----------------------------------------------------------------------------
// Reset clears the store one word a cycle, all 65536 words, with s_tready low, while
// configuration writes are taken. Each step is one microcode word on one store port.
// A page request reads its directory entry and then its table entry, allocating a table
// and/or page where an entry is not present, or fails; its result is valid when s_tready
// rises again. A create request makes 768 clear writes and 255 read/write copy pairs
// before the self map write; a failed create ends at its kernel or frame check.
module two_level_page_table_walk_alloc
	import tplw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// s_tdata: virtual_address[31:0], writeable[32], user[33], zero fill
	input  logic [DATA_W-1:0] s_tdata,
	// s_tuser: action[0]
	input  logic [0:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// m_tdata: physical_address[31:0], status[33:32], table_allocated[34],
	// page_allocated[35], zero fill
	output logic [DATA_W-1:0] m_tdata,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	ctrl_t  ctrl;
	flags_t flags;

	// Table store.
	word_t              mem [0:DEPTH-1];
	logic               mem_we;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ADDR_W-1:0]  mem_raddr;
	word_t              mem_wdata;
	word_t              rdata_q;

	// Control state.
	logic [ADDR_W-1:0]  clr_q;
	logic [NEXT_W-1:0]  next_q;
	logic [7:0]         kern_q;
	logic [FRAME_W-1:0] cur_q;
	logic               m_valid_q;

	// Request and working registers.
	logic [31:0]        va_q;
	logic               wr_q;
	logic               us_q;
	logic               page_q;
	logic               tbl_new_q;
	logic [FRAME_W-1:0] dir_q;
	logic [FRAME_W-1:0] tbl_q;
	logic [IDX_W-1:0]   idx_q;
	logic [31:0]        res_addr_q;
	logic [1:0]         res_status_q;
	logic               res_tbl_q;
	logic               res_pg_q;
	logic [DATA_W-1:0]  m_data_q;

	logic               accept;
	logic               out_free;

	tplw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// Handshakes.
	assign s_tready = (ctrl.op == OP_WAIT);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Conditions for the sequencer.
	always_comb begin
		flags.clr_done     = (clr_q == ADDR_W'(DEPTH - 1));
		flags.accept       = accept;
		flags.page         = (page_q == ACT_PAGE);
		flags.kern_bad     = ({1'b0, kern_q} >= NEXT_W'(FRAMES));
		flags.no_frame     = (next_q >= NEXT_W'(FRAMES));
		flags.idx_clr_more = (idx_q != IDX_W'(KERNEL_FIRST - 1));
		flags.idx_cpy_more = (idx_q != IDX_W'(SELF_MAP - 1));
		flags.entry_p      = rdata_q[0];
		flags.tbl_bad      = (rdata_q[31:12] >= PFN_W'(FRAMES));
		flags.out_free     = out_free;
	end

	// Store port selection for the current step.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = '0;
		mem_raddr = '0;
		mem_wdata = '0;
		case (ctrl.op)
			OP_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			OP_CR_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = {dir_q, idx_q};
			end
			OP_CR_CPRD: begin
				mem_re    = 1'b1;
				mem_raddr = {kern_q[FRAME_W-1:0], idx_q};
			end
			OP_CR_CPWR: begin
				mem_we    = 1'b1;
				mem_waddr = {dir_q, idx_q};
				mem_wdata = rdata_q;
			end
			OP_CR_SELF: begin
				mem_we    = 1'b1;
				mem_waddr = {dir_q, IDX_W'(SELF_MAP)};
				mem_wdata = {PFN_W'(dir_q), FLAG_P | FLAG_W};
			end
			OP_RD_DIR: begin
				mem_re    = 1'b1;
				mem_raddr = {cur_q, va_q[31:22]};
			end
			OP_T_ALLOC: begin
				mem_we    = 1'b1;
				mem_waddr = {cur_q, va_q[31:22]};
				mem_wdata = {PFN_W'(next_q), FLAG_P | FLAG_W | FLAG_U};
			end
			OP_RD_TBL: begin
				mem_re    = 1'b1;
				mem_raddr = {tbl_q, va_q[21:12]};
			end
			OP_P_ALLOC: begin
				mem_we    = 1'b1;
				mem_waddr = {tbl_q, va_q[21:12]};
				mem_wdata = {PFN_W'(next_q), 9'b0, us_q, wr_q, 1'b1};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Word store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Clearing pointer, allocator, kernel directory, current directory and
	// output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			next_q    <= NEXT_W'(1);
			kern_q    <= '0;
			cur_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index[0])
					REG_FIRST_FREE: next_q <= {1'b0, cfg_data};
					REG_KERNEL_DIR: kern_q <= cfg_data;
					default:        kern_q <= kern_q;
				endcase
			end else if (ctrl.op == OP_CR_ALLOC || ctrl.op == OP_T_ALLOC ||
					ctrl.op == OP_P_ALLOC) begin
				next_q <= next_q + 1'b1;
			end
			if (ctrl.op == OP_CR_SELF) begin
				cur_q <= dir_q;
			end
			if (ctrl.op == OP_RESULT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result staging.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_WAIT: begin
				if (accept) begin
					va_q      <= s_tdata[31:0];
					wr_q      <= s_tdata[32];
					us_q      <= s_tdata[33];
					page_q    <= s_tuser[0];
					tbl_new_q <= 1'b0;
				end
			end
			OP_CR_ALLOC: begin
				dir_q <= next_q[FRAME_W-1:0];
				idx_q <= '0;
			end
			OP_CR_CLR, OP_CR_CPWR: begin
				idx_q <= idx_q + 1'b1;
			end
			OP_CR_SELF: begin
				res_addr_q   <= {PFN_W'(dir_q), 12'b0};
				res_status_q <= STATUS_OK;
				res_tbl_q    <= 1'b0;
				res_pg_q     <= 1'b0;
			end
			OP_T_ALLOC: begin
				tbl_q     <= next_q[FRAME_W-1:0];
				tbl_new_q <= 1'b1;
			end
			OP_T_TAKE: begin
				tbl_q <= rdata_q[12 +: FRAME_W];
			end
			OP_P_ALLOC: begin
				res_addr_q   <= {PFN_W'(next_q), 12'b0};
				res_status_q <= STATUS_OK;
				res_tbl_q    <= tbl_new_q;
				res_pg_q     <= 1'b1;
			end
			OP_HIT: begin
				res_addr_q   <= {rdata_q[31:12], 12'b0};
				res_status_q <= STATUS_OK;
				res_tbl_q    <= tbl_new_q;
				res_pg_q     <= 1'b0;
			end
			OP_FAIL1: begin
				res_addr_q   <= '0;
				res_status_q <= STATUS_NO_FRAME;
				res_tbl_q    <= tbl_new_q;
				res_pg_q     <= 1'b0;
			end
			OP_FAIL2: begin
				res_addr_q   <= '0;
				res_status_q <= STATUS_BAD_FRAME;
				res_tbl_q    <= 1'b0;
				res_pg_q     <= 1'b0;
			end
			OP_RESULT: begin
				if (out_free) begin
					m_data_q <= {4'b0, res_pg_q, res_tbl_q, res_status_q, res_addr_q};
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

>>> hw/rtl/tplw_check.sv
// ----------------------------------------------------------------------------
// tplw_check: port checker for the page table walker
// Watches the top level's ports and flags results or handshakes that the
// walker can never produce; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module tplw_check
	import tplw_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// A stalled result item holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("result item changed while stalled");

	// One item at a time: an accepted item closes the input until it is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("input item accepted while another is at work");

	// A failed request returns no address and no new page.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != STATUS_OK |->
			m_tdata[31:0] == 32'd0 && !m_tdata[35])
	else $error("failed result carries an address or a page");

	// Status codes stay in range and the returned address is page aligned.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3 && m_tdata[11:0] == 12'd0)
	else $error("bad status code or unaligned address");

endmodule

bind two_level_page_table_walk_alloc tplw_check u_tplw_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
